@@ design/ihf_pkg.sv @@
package ihf_pkg;

    // Counts hold up to the maximum header length in words plus one (overflow mark).
    localparam int CNT_W = 5;

    // APB register map, one 32-bit register every 4 bytes
    localparam int PADDR_W          = 5;
    localparam int REG_ROUTE_BASE   = 0;
    localparam int REG_ROUTES_IN_USE = 6;
    localparam int MAX_ROUTES       = 3;

    localparam logic [31:0] PREFIX_RST [MAX_ROUTES] = '{32'hC0A8_0100, 32'hC0A8_0200, 32'h0};
    localparam logic [31:0] MASK_RST   [MAX_ROUTES] = '{32'hFFFF_FF00, 32'hFFFF_FF00, 32'h0};
    localparam logic [1:0]  ROUTES_IN_USE_RST = 2'd2;

    // Header word positions
    localparam int WIDX_VER    = 0;
    localparam int WIDX_TTL    = 4;
    localparam int WIDX_CSUM   = 5;
    localparam int WIDX_DST_HI = 8;
    localparam int WIDX_DST_LO = 9;
    localparam logic [3:0] IHL_MIN = 4'd5;
    localparam logic [7:0] TTL_MIN = 8'd1;

    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        V_FWD       = 2'd0,
        V_TTL       = 2'd1,
        V_NOROUTE   = 2'd2,
        V_MALFORMED = 2'd3
    } t_verdict;

    // One classified header, handed from front to back
    typedef struct packed {
        t_verdict         verdict;
        logic [1:0]       port;
        logic [CNT_W-1:0] count;
        logic             bank;
        logic [15:0]      csum;
    } t_job;

    // Header store write port
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [CNT_W-1:0] idx;
        logic [15:0]      data;
    } t_wr;

    typedef struct packed {
        logic full;
        logic avail;
    } t_qflags;

endpackage

@@ design/ihf_cfg.sv @@
module ihf_cfg #(
    parameter int ROUTE_SLOTS = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ihf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [31:0]                 o_prefix [ROUTE_SLOTS],
    output logic [31:0]                 o_mask   [ROUTE_SLOTS],
    output logic [1:0]                  o_routes_in_use
);

    logic [31:0] r_prefix [ROUTE_SLOTS];
    logic [31:0] r_mask   [ROUTE_SLOTS];
    logic [1:0]  r_riu;
    logic [2:0]  widx;
    logic        wr;

    assign widx   = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < ROUTE_SLOTS; s++) begin
                r_prefix[s] <= ihf_pkg::PREFIX_RST[s];
                r_mask[s]   <= ihf_pkg::MASK_RST[s];
            end
            r_riu <= ihf_pkg::ROUTES_IN_USE_RST;
        end else if (wr) begin
            for (int s = 0; s < ROUTE_SLOTS; s++) begin
                if (widx == 3'(ihf_pkg::REG_ROUTE_BASE + 2 * s)) begin
                    r_prefix[s] <= pwdata;
                end
                if (widx == 3'(ihf_pkg::REG_ROUTE_BASE + 2 * s + 1)) begin
                    r_mask[s] <= pwdata;
                end
            end
            if (widx == 3'(ihf_pkg::REG_ROUTES_IN_USE)) begin
                r_riu <= pwdata[1:0];
            end
        end
    end

    // slots beyond ROUTE_SLOTS read as zero
    always_comb begin
        prdata = '0;
        for (int s = 0; s < ROUTE_SLOTS; s++) begin
            if (widx == 3'(ihf_pkg::REG_ROUTE_BASE + 2 * s)) begin
                prdata = r_prefix[s];
            end
            if (widx == 3'(ihf_pkg::REG_ROUTE_BASE + 2 * s + 1)) begin
                prdata = r_mask[s];
            end
        end
        if (widx == 3'(ihf_pkg::REG_ROUTES_IN_USE)) begin
            prdata = {30'd0, r_riu};
        end
    end

    assign o_prefix        = r_prefix;
    assign o_mask          = r_mask;
    assign o_routes_in_use = r_riu;

endmodule

@@ design/ihf_front.sv @@
module ihf_front #(
    parameter int MAX_HEADER_WORDS = 30,
    parameter int ROUTE_SLOTS      = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [15:0]           i_header_word,
    input  logic                  i_word_is_last,
    input  logic [31:0]           i_prefix [ROUTE_SLOTS],
    input  logic [31:0]           i_mask   [ROUTE_SLOTS],
    input  logic [1:0]            i_routes_in_use,
    input  ihf_pkg::t_qflags      i_q,
    output ihf_pkg::t_wr          o_wr,
    output logic                  o_push,
    output ihf_pkg::t_job         o_job
);

    localparam int CW = ihf_pkg::CNT_W;

    logic          r_pend;
    logic          r_bank;
    logic [CW-1:0] r_taken;
    logic [CW-1:0] r_count;
    logic [15:0]   r_acc;
    logic [15:0]   r_sum;
    logic [3:0]    r_ihl;
    logic [7:0]    r_ttl;
    logic [31:0]   r_dst;

    logic          accept;
    logic          room;
    logic [15:0]   term;
    logic [16:0]   sum17;
    logic [15:0]   n_acc;
    logic          malformed;
    logic          found;
    logic [1:0]    port;

    assign o_in_stall = r_pend || i_q.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign room       = r_taken < CW'(MAX_HEADER_WORDS);

    assign o_wr.en   = accept && room;
    assign o_wr.bank = r_bank;
    assign o_wr.idx  = r_taken;
    assign o_wr.data = i_header_word;

    // running ones' complement sum: TTL already decremented, checksum word as zero
    always_comb begin
        term = i_header_word;
        if (r_taken == CW'(ihf_pkg::WIDX_TTL)) begin
            term = {i_header_word[15:8] - 8'd1, i_header_word[7:0]};
        end else if (r_taken == CW'(ihf_pkg::WIDX_CSUM)) begin
            term = '0;
        end
        sum17 = {1'b0, r_acc} + {1'b0, term};
        n_acc = sum17[15:0] + 16'(sum17[16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_bank  <= 1'b0;
            r_taken <= '0;
            r_acc   <= '0;
        end else begin
            if (r_pend) begin
                r_pend <= 1'b0;
                r_bank <= !r_bank;
            end else if (accept) begin
                if (i_word_is_last) begin
                    r_pend  <= 1'b1;
                    r_taken <= '0;
                    r_acc   <= '0;
                end else if (room) begin
                    r_taken <= r_taken + CW'(1);
                    r_acc   <= n_acc;
                end else begin
                    r_taken <= CW'(MAX_HEADER_WORDS + 1);
                end
            end
        end
    end

    // header fields and the totals taken on the last word
    always_ff @(posedge i_clk) begin
        if (accept && room) begin
            if (r_taken == CW'(ihf_pkg::WIDX_VER))    r_ihl <= i_header_word[11:8];
            if (r_taken == CW'(ihf_pkg::WIDX_TTL))    r_ttl <= i_header_word[15:8];
            if (r_taken == CW'(ihf_pkg::WIDX_DST_HI)) r_dst[31:16] <= i_header_word;
            if (r_taken == CW'(ihf_pkg::WIDX_DST_LO)) r_dst[15:0]  <= i_header_word;
        end
        if (accept && i_word_is_last) begin
            r_count <= room ? r_taken + CW'(1) : CW'(MAX_HEADER_WORDS + 1);
            r_sum   <= room ? n_acc : r_acc;
        end
    end

    // first-match route lookup
    always_comb begin
        found = 1'b0;
        port  = '0;
        for (int s = 0; s < ROUTE_SLOTS; s++) begin
            if (!found && (2'(s) < i_routes_in_use) &&
                ((r_dst & i_mask[s]) == (i_prefix[s] & i_mask[s]))) begin
                found = 1'b1;
                port  = 2'(s);
            end
        end
    end

    assign malformed = (r_count > CW'(MAX_HEADER_WORDS)) || (r_ihl < ihf_pkg::IHL_MIN) ||
                       (r_count != CW'({r_ihl, 1'b0}));

    always_comb begin
        o_job.count = r_count;
        o_job.bank  = r_bank;
        o_job.csum  = ~r_sum;
        o_job.port  = '0;
        if (malformed) begin
            o_job.verdict = ihf_pkg::V_MALFORMED;
        end else if (r_ttl <= ihf_pkg::TTL_MIN) begin
            o_job.verdict = ihf_pkg::V_TTL;
        end else if (!found) begin
            o_job.verdict = ihf_pkg::V_NOROUTE;
        end else begin
            o_job.verdict = ihf_pkg::V_FWD;
            o_job.port    = port;
        end
    end

    assign o_push = r_pend;

endmodule

@@ design/ihf_queue.sv @@
module ihf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ihf_pkg::t_job    i_job,
    input  logic             i_pop,
    output ihf_pkg::t_job    o_job,
    output ihf_pkg::t_qflags o_q
);

    localparam int PW = $clog2(ihf_pkg::QDEPTH);

    ihf_pkg::t_job r_slot [ihf_pkg::QDEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + PW'(1);
            if (i_pop)  r_rp <= r_rp + PW'(1);
            r_cnt <= r_cnt + (PW + 1)'(i_push) - (PW + 1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_job;
    end

    assign o_job     = r_slot[r_rp];
    assign o_q.full  = r_cnt == (PW + 1)'(ihf_pkg::QDEPTH);
    assign o_q.avail = r_cnt != '0;

endmodule

@@ design/ihf_back.sv @@
module ihf_back #(
    parameter int MAX_HEADER_WORDS = 30
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ihf_pkg::t_wr     i_wr,
    input  ihf_pkg::t_job    i_job,
    input  ihf_pkg::t_qflags i_q,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [15:0]      o_out_word,
    output logic             o_out_last,
    output logic [1:0]       o_verdict,
    output logic [1:0]       o_egress_port
);

    localparam int CW    = ihf_pkg::CNT_W;
    localparam int IW    = $clog2(MAX_HEADER_WORDS);
    localparam int DEPTH = 2 * (2 ** IW);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SEND = 3'b100
    } t_state;

    // two banks: front fills one while the other drains
    logic [15:0]      r_mem [DEPTH];
    logic [15:0]      r_rd_data;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic [15:0]      r_out_word, n_out_word;
    logic             r_out_last, n_out_last;
    ihf_pkg::t_verdict r_out_verdict, n_out_verdict;
    logic [1:0]       r_out_port, n_out_port;
    logic             rd_en;
    logic             out_free;
    logic             is_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[{i_wr.bank, i_wr.idx[IW-1:0]}] <= i_wr.data;
        if (rd_en)   r_rd_data <= r_mem[{i_job.bank, r_idx[IW-1:0]}];
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign is_last  = r_idx == i_job.count - CW'(1);

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_word    = r_out_word;
        n_out_last    = r_out_last;
        n_out_verdict = r_out_verdict;
        n_out_port    = r_out_port;
        rd_en         = 1'b0;
        o_pop         = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q.avail) begin
                    if (i_job.verdict != ihf_pkg::V_FWD) begin
                        if (out_free) begin
                            n_out_valid   = 1'b1;
                            n_out_word    = '0;
                            n_out_last    = 1'b1;
                            n_out_verdict = i_job.verdict;
                            n_out_port    = '0;
                            o_pop         = 1'b1;
                        end
                    end else begin
                        n_idx   = '0;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    // store holds the words as received: patch TTL and checksum
                    if (r_idx == CW'(ihf_pkg::WIDX_CSUM)) begin
                        n_out_word = i_job.csum;
                    end else if (r_idx == CW'(ihf_pkg::WIDX_TTL)) begin
                        n_out_word = {r_rd_data[15:8] - 8'd1, r_rd_data[7:0]};
                    end else begin
                        n_out_word = r_rd_data;
                    end
                    n_out_last    = is_last;
                    n_out_verdict = ihf_pkg::V_FWD;
                    n_out_port    = i_job.port;
                    if (is_last) begin
                        o_pop   = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_idx         <= n_idx;
        r_out_word    <= n_out_word;
        r_out_last    <= n_out_last;
        r_out_verdict <= n_out_verdict;
        r_out_port    <= n_out_port;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_word    = r_out_word;
    assign o_out_last    = r_out_last;
    assign o_verdict     = r_out_verdict;
    assign o_egress_port = r_out_port;

endmodule

@@ design/ipv4_header_forward.sv @@
// IPv4 header forwarding stage.
// Input channel (i_in_valid / o_in_stall): one 16-bit header word per item,
// network order, i_word_is_last on the final word. Words enter one per cycle while o_in_stall is low.
// Output channel (o_out_valid / i_out_stall): forwarded header words with
// TTL decremented and checksum rewritten, tagged with the first matching
// route as o_egress_port, or one status-only item (word 0, last 1) for a
// malformed header, an expired TTL or no matching route.
// The last word is classified in the cycle after it is taken; the job then
// passes the job queue, and the back loads a status item into the output
// register, or per forwarded word does a registered store read and then the
// output load, so the next word is read only after the previous one is
// loaded. The input is held after each last word while it is classified.
// A two-entry job queue and two store banks let the next header come in
// while the previous one drains; the input stalls when both banks are held.
// Reset (synchronous, active low) empties queue and output, clears the word
// count and loads the default routes. A stalled output item holds; back
// pressure fills the queue and then stalls the input. Route s has its prefix
// at APB byte address 8*s and its mask at 8*s+4. The user must write routes
// only while idle; the block itself does not enforce this.
module ipv4_header_forward #(
    parameter int MAX_HEADER_WORDS = 30,
    parameter int ROUTE_SLOTS      = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // header word input
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [15:0]                 i_header_word,
    input  logic                        i_word_is_last,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [15:0]                 o_out_word,
    output logic                        o_out_last,
    output logic [1:0]                  o_verdict,
    output logic [1:0]                  o_egress_port,
    // APB config
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ihf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [31:0]      prefix [ROUTE_SLOTS];
    logic [31:0]      mask   [ROUTE_SLOTS];
    logic [1:0]       routes_in_use;
    ihf_pkg::t_wr     wr;
    ihf_pkg::t_job    push_job;
    ihf_pkg::t_job    head_job;
    ihf_pkg::t_qflags qflags;
    logic             push;
    logic             pop;

    ihf_cfg #(
        .ROUTE_SLOTS (ROUTE_SLOTS)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_prefix        (prefix),
        .o_mask          (mask),
        .o_routes_in_use (routes_in_use)
    );

    // front: store words, build checksum, classify on the last word
    ihf_front #(
        .MAX_HEADER_WORDS (MAX_HEADER_WORDS),
        .ROUTE_SLOTS      (ROUTE_SLOTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_header_word   (i_header_word),
        .i_word_is_last  (i_word_is_last),
        .i_prefix        (prefix),
        .i_mask          (mask),
        .i_routes_in_use (routes_in_use),
        .i_q             (qflags),
        .o_wr            (wr),
        .o_push          (push),
        .o_job           (push_job)
    );

    // job stays queued until the back loads its last item into the output register
    ihf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_q     (qflags)
    );

    // back: read the store and emit results
    ihf_back #(
        .MAX_HEADER_WORDS (MAX_HEADER_WORDS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (wr),
        .i_job         (head_job),
        .i_q           (qflags),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word),
        .o_out_last    (o_out_last),
        .o_verdict     (o_verdict),
        .o_egress_port (o_egress_port)
    );

endmodule

@@ design/ihf_checker.sv @@
module ihf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_word_is_last,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_out_word,
    input logic        o_out_last,
    input logic [1:0]  o_verdict,
    input logic [1:0]  o_egress_port
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_word) && $stable(o_out_last) &&
            $stable(o_verdict) && $stable(o_egress_port))
        else $error("stalled result changed");

    // status results are a single zero word on port 0
    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_verdict != ihf_pkg::V_FWD) |->
            o_out_last && (o_out_word == 16'd0) && (o_egress_port == 2'd0))
        else $error("bad status result");

    // only three route slots exist
    a_port_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_egress_port != 2'd3)
        else $error("egress port out of range");

    // input is held for the classify cycle after a last word
    a_classify_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_word_is_last |=> o_in_stall)
        else $error("input taken during classify");

endmodule

bind ipv4_header_forward ihf_checker u_ihf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_word_is_last (i_word_is_last),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out_word     (o_out_word),
    .o_out_last     (o_out_last),
    .o_verdict      (o_verdict),
    .o_egress_port  (o_egress_port)
);
